// ===== sv/ppds_pkg.sv =====
// ----------------------------------------------------------------------------
// ppds_pkg
// Shared constants and types of the point projection depth splatter.
// ----------------------------------------------------------------------------
package ppds_pkg;

    localparam int FRAME_WIDTH      = 640;
    localparam int FRAME_HEIGHT     = 480;
    localparam int MAX_SPLAT_RADIUS = 8;

    localparam int DEPTH_ENTRIES = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W        = $clog2(DEPTH_ENTRIES);
    localparam int U_W           = $clog2(FRAME_WIDTH);
    localparam int V_W           = $clog2(FRAME_HEIGHT);
    localparam int XS_W          = U_W + 2;
    localparam int YS_W          = V_W + 2;
    localparam int RAD_W         = $clog2(MAX_SPLAT_RADIUS + 1);

    localparam int DEPTH_W = 16;
    localparam int NUM_W   = 42;
    localparam int DEN_W   = 20;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam int MIN_DEPTH_Q10    = 102;
    localparam int RADIUS_NUMERATOR = 8192;

    localparam logic [2:0] REG_ROT_ROW0    = 3'd0;
    localparam logic [2:0] REG_ROT_ROW1    = 3'd1;
    localparam logic [2:0] REG_ROT_ROW2    = 3'd2;
    localparam logic [2:0] REG_TRANSLATION = 3'd3;
    localparam logic [2:0] REG_FOCAL       = 3'd4;
    localparam logic [2:0] REG_PRINCIPAL   = 3'd5;
    localparam logic [2:0] REG_MAX_DEPTH   = 3'd6;
    localparam logic [2:0] REG_POSE_VALID  = 3'd7;

    localparam logic OP_SPLAT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIVU,
        ST_DIVV,
        ST_DIVR,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [ADDR_W-1:0]   addr;
        logic [DEPTH_W-1:0]  data;
    } mem_req_t;

endpackage

// ===== sv/ppds_div.sv =====
// ----------------------------------------------------------------------------
// ppds_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppds_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ppds_pkg::NUM_W-1:0]   num,
    input  logic [ppds_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [ppds_pkg::NUM_W-1:0]   quot
);
    import ppds_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ~diff[DEN_W+1]};
            rem_next = diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== sv/ppds_store.sv =====
// ----------------------------------------------------------------------------
// ppds_store
// Depth store memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
module ppds_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppds_pkg::mem_req_t            req,
    output logic [ppds_pkg::DEPTH_W-1:0]  rd_data,
    output logic                          clr_busy
);
    import ppds_pkg::*;

    logic [DEPTH_W-1:0] mem [DEPTH_ENTRIES];
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               clr_busy_reg, clr_busy_next;
    logic [DEPTH_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DEPTH_W-1:0] wr_data;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH_ENTRIES - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
        wr_en   = clr_busy_reg | req.wr;
        wr_addr = clr_busy_reg ? clr_addr_reg : req.addr;
        wr_data = clr_busy_reg ? '0 : req.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== sv/point_projection_depth_splat.sv =====
// ----------------------------------------------------------------------------
// point_projection_depth_splat
// Projects world points into a nearest-depth image and reads pixels back.
// ----------------------------------------------------------------------------
// Items enter on the s_ group; tuser holds the opcode. A splat item rotates
// the point into the camera frame with one shared multiply-accumulate unit
// (13 products, each through a multiply and an accumulate state), divides
// for the column, the row and the splat radius on one bit-serial divider,
// then walks the square of pixels with a read state and a compare-write
// state for each pixel inside the frame. A dropped splat returns to idle
// without the walk. A read item presents one pixel_depth transfer on the m_
// group while clearing the pixel.
// The block takes one item at a time; s_tready is high only when idle.
// After reset the depth store is cleared one entry per cycle, and no item is
// taken meanwhile; configuration writes are taken at any time. A stalled
// receiver holds the result in the output register, and a read item waits
// for that register before it completes.
// ----------------------------------------------------------------------------
module point_projection_depth_splat (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // point_x, point_y, point_z, pixel_column, pixel_row
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_depth
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data
);
    import ppds_pkg::*;

    logic [47:0] rot0_reg, rot1_reg, rot2_reg;
    logic [59:0] trans_reg;
    logic [31:0] focal_reg, principal_reg;
    logic [15:0] max_depth_reg;
    logic        pose_valid_reg;

    state_t state_reg, state_next;
    logic [3:0]                 step_reg, step_next;
    logic signed [20:0]         d_reg [3];
    logic signed [20:0]         d_next [3];
    logic signed [24:0]         c_reg [3];
    logic signed [24:0]         c_next [3];
    logic signed [41:0]         prod_reg, prod_next;
    logic signed [42:0]         acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic [DEPTH_W-1:0]         depth_reg, depth_next;
    logic [U_W-1:0]             u_reg, u_next;
    logic [V_W-1:0]             v_reg, v_next;
    logic [RAD_W-1:0]           rad_reg, rad_next;
    logic signed [RAD_W:0]      du_reg, du_next, dv_reg, dv_next;
    logic [9:0]                 col_reg, col_next;
    logic [8:0]                 row_reg, row_next;
    logic                       out_valid_reg, out_valid_next;
    logic [DEPTH_W-1:0]         out_data_reg, out_data_next;

    logic signed [24:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic                mul_sub;
    logic signed [42:0]  acc_sum;
    logic signed [42:0]  acc_mag;
    logic signed [42:0]  acc_shr;
    logic                accept;
    logic signed [XS_W-1:0] x_pos;
    logic signed [YS_W-1:0] y_pos;
    logic                walk_in;
    logic                rd_in;
    logic                walk_last_col;
    logic signed [RAD_W:0] rad_s;
    logic [U_W-1:0]      x_idx;
    logic [V_W-1:0]      y_idx;
    logic [ADDR_W-1:0]   addr;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic               quot_in_w;
    logic               quot_in_h;

    mem_req_t           mem_req;
    logic [DEPTH_W-1:0] mem_rd_data;
    logic               clr_busy;

    ppds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    ppds_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_data  (mem_rd_data),
        .clr_busy (clr_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg       <= 48'd16384;
            rot1_reg       <= 48'd1073741824;
            rot2_reg       <= 48'd70368744177664;
            trans_reg      <= '0;
            focal_reg      <= 32'd406067252;
            principal_reg  <= 32'd255267857;
            max_depth_reg  <= 16'd10240;
            pose_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROT_ROW0:    rot0_reg       <= cfg_data[47:0];
                REG_ROT_ROW1:    rot1_reg       <= cfg_data[47:0];
                REG_ROT_ROW2:    rot2_reg       <= cfg_data[47:0];
                REG_TRANSLATION: trans_reg      <= cfg_data;
                REG_FOCAL:       focal_reg      <= cfg_data[31:0];
                REG_PRINCIPAL:   principal_reg  <= cfg_data[31:0];
                REG_MAX_DEPTH:   max_depth_reg  <= cfg_data[15:0];
                REG_POSE_VALID:  pose_valid_reg <= cfg_data[0];
                default:         pose_valid_reg <= pose_valid_reg;
            endcase
        end
    end

    always_comb
    begin
        mul_sub = 1'b0;
        case (step_reg)
            4'd0:    begin mul_a = 25'(d_reg[0]); mul_b = 17'($signed(rot0_reg[15:0]));  end
            4'd1:    begin mul_a = 25'(d_reg[1]); mul_b = 17'($signed(rot0_reg[31:16])); end
            4'd2:    begin mul_a = 25'(d_reg[2]); mul_b = 17'($signed(rot0_reg[47:32])); end
            4'd3:    begin mul_a = 25'(d_reg[0]); mul_b = 17'($signed(rot1_reg[15:0]));  end
            4'd4:    begin mul_a = 25'(d_reg[1]); mul_b = 17'($signed(rot1_reg[31:16])); end
            4'd5:    begin mul_a = 25'(d_reg[2]); mul_b = 17'($signed(rot1_reg[47:32])); end
            4'd6:    begin mul_a = 25'(d_reg[0]); mul_b = 17'($signed(rot2_reg[15:0]));  end
            4'd7:    begin mul_a = 25'(d_reg[1]); mul_b = 17'($signed(rot2_reg[31:16])); end
            4'd8:    begin mul_a = 25'(d_reg[2]); mul_b = 17'($signed(rot2_reg[47:32])); end
            4'd9:    begin mul_a = c_reg[1]; mul_b = $signed({1'b0, focal_reg[15:0]});     end
            4'd10:   begin mul_a = c_reg[0]; mul_b = $signed({1'b0, principal_reg[15:0]}); end
            4'd11:
            begin
                mul_a   = c_reg[2];
                mul_b   = $signed({1'b0, focal_reg[31:16]});
                mul_sub = 1'b1;
            end
            4'd12:   begin mul_a = c_reg[0]; mul_b = $signed({1'b0, principal_reg[31:16]}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        acc_sum   = mul_sub ? acc_reg - 43'(prod_reg) : acc_reg + 43'(prod_reg);
        acc_mag   = acc_sum[42] ? -acc_sum : acc_sum;
        acc_shr   = acc_sum >>> 14;
        accept    = s_tvalid & s_tready;
        rad_s     = $signed({1'b0, rad_reg});
        x_pos     = $signed({2'b00, u_reg}) + XS_W'(du_reg);
        y_pos     = $signed({2'b00, v_reg}) + YS_W'(dv_reg);
        walk_in   = !x_pos[XS_W-1] && ($unsigned(x_pos) < XS_W'(FRAME_WIDTH))
                 && !y_pos[YS_W-1] && ($unsigned(y_pos) < YS_W'(FRAME_HEIGHT));
        rd_in     = (32'(col_reg) < FRAME_WIDTH) && (32'(row_reg) < FRAME_HEIGHT);
        walk_last_col = (du_reg == rad_s);
        quot_in_w = (div_quot == '0) || (!neg_reg && div_quot < NUM_W'(FRAME_WIDTH));
        quot_in_h = (div_quot == '0) || (!neg_reg && div_quot < NUM_W'(FRAME_HEIGHT));
        if (state_reg == ST_RD_ISSUE || state_reg == ST_RD_DATA)
        begin
            x_idx = U_W'(col_reg);
            y_idx = V_W'(row_reg);
        end
        else
        begin
            x_idx = x_pos[U_W-1:0];
            y_idx = y_pos[V_W-1:0];
        end
        addr = ADDR_W'(y_idx) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(x_idx);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        depth_next     = depth_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        rad_next       = rad_reg;
        du_next        = du_reg;
        dv_next        = dv_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_num        = acc_mag[NUM_W-1:0];
        div_den        = {depth_reg, 4'b0000};
        mem_req.rd     = 1'b0;
        mem_req.wr     = 1'b0;
        mem_req.addr   = addr;
        mem_req.data   = depth_reg;
        s_tready       = (state_reg == ST_IDLE) && !clr_busy;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next = s_tdata[69:60];
                    row_next = s_tdata[78:70];
                    d_next[0] = 21'($signed(s_tdata[19:0])) - 21'($signed(trans_reg[19:0]));
                    d_next[1] = 21'($signed(s_tdata[39:20])) - 21'($signed(trans_reg[39:20]));
                    d_next[2] = 21'($signed(s_tdata[59:40])) - 21'($signed(trans_reg[59:40]));
                    step_next = '0;
                    acc_next  = '0;
                    if (s_tuser == OP_READ)
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                    else if (pose_valid_reg)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_sum;
                step_next  = step_reg + 1'b1;
                state_next = ST_MUL;
                case (step_reg)
                    4'd2:
                    begin
                        c_next[0] = acc_shr[24:0];
                        acc_next  = '0;
                    end
                    4'd5:
                    begin
                        c_next[1] = acc_shr[24:0];
                        acc_next  = '0;
                    end
                    4'd8:
                    begin
                        c_next[2] = acc_shr[24:0];
                        acc_next  = '0;
                        state_next = ST_CHECK;
                    end
                    4'd10:
                    begin
                        div_start  = 1'b1;
                        neg_next   = acc_sum[42];
                        state_next = ST_DIVU;
                    end
                    4'd12:
                    begin
                        div_start  = 1'b1;
                        neg_next   = acc_sum[42];
                        state_next = ST_DIVV;
                    end
                    default:
                    begin
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_CHECK:
            begin
                depth_next = c_reg[0][15:0];
                if (c_reg[0] <= 25'sd102 || c_reg[0] > $signed({9'b0, max_depth_reg}))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_DIVU:
            begin
                if (div_done)
                begin
                    u_next   = div_quot[U_W-1:0];
                    acc_next = '0;
                    state_next = quot_in_w ? ST_MUL : ST_IDLE;
                end
            end
            ST_DIVV:
            begin
                if (div_done)
                begin
                    v_next = div_quot[V_W-1:0];
                    if (quot_in_h)
                    begin
                        div_start  = 1'b1;
                        div_num    = NUM_W'(RADIUS_NUMERATOR);
                        div_den    = DEN_W'(depth_reg);
                        state_next = ST_DIVR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIVR:
            begin
                if (div_done)
                begin
                    if (div_quot >= NUM_W'(MAX_SPLAT_RADIUS))
                    begin
                        rad_next = RAD_W'(MAX_SPLAT_RADIUS);
                    end
                    else if (div_quot == '0)
                    begin
                        rad_next = RAD_W'(1);
                    end
                    else
                    begin
                        rad_next = div_quot[RAD_W-1:0];
                    end
                    du_next    = -$signed({1'b0, rad_next});
                    dv_next    = -$signed({1'b0, rad_next});
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD, ST_WALK_CMP:
            begin
                if (state_reg == ST_WALK_RD && walk_in)
                begin
                    mem_req.rd = 1'b1;
                    state_next = ST_WALK_CMP;
                end
                else
                begin
                    if (state_reg == ST_WALK_CMP
                        && (mem_rd_data == '0 || depth_reg < mem_rd_data))
                    begin
                        mem_req.wr = 1'b1;
                    end
                    state_next = ST_WALK_RD;
                    if (walk_last_col)
                    begin
                        du_next = -rad_s;
                        dv_next = dv_reg + 1'b1;
                        if (dv_reg == rad_s)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        du_next = du_reg + 1'b1;
                    end
                end
            end
            ST_RD_ISSUE:
            begin
                mem_req.rd = rd_in;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_in ? mem_rd_data : '0;
                    mem_req.wr     = rd_in;
                    mem_req.data   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        c_reg        <= c_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        depth_reg    <= depth_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        rad_reg      <= rad_next;
        du_reg       <= du_next;
        dv_reg       <= dv_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !clr_busy)
        else $error("item taken while the depth store is being cleared");

    a_walk_write_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr && state_reg == ST_WALK_CMP) |-> (depth_reg != '0 && mem_req.data == depth_reg))
        else $error("splat write carries an empty or wrong depth");

    a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_RD) |-> (rad_reg != '0 && rad_reg <= RAD_W'(MAX_SPLAT_RADIUS)))
        else $error("splat radius out of range");

    a_read_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_ISSUE) |=> (state_reg == ST_RD_DATA))
        else $error("read item lost its data cycle");

endmodule

// ===== test/tb_point_projection_depth_splat.sv =====
// ----------------------------------------------------------------------------
// tb_point_projection_depth_splat
// Self-checking testbench of the point projection depth splatter.
// ----------------------------------------------------------------------------
// Splat and read items are queued by phase, driven with random gaps, and every
// pixel_depth transfer is compared with a local depth image that is updated by
// the same fixed-point projection. The camera settings change between phases.
// ----------------------------------------------------------------------------
module tb_point_projection_depth_splat;
    import ppds_pkg::*;

    typedef struct packed {
        logic        op;
        logic [19:0] px;
        logic [19:0] py;
        logic [19:0] pz;
        logic [9:0]  col;
        logic [8:0]  row;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_data;

    point_projection_depth_splat dut (.*);

    logic [15:0] depth_image [DEPTH_ENTRIES];
    logic [47:0] rot [3];
    logic [59:0] cam_pos;
    logic [31:0] focal;
    logic [31:0] center;
    logic [15:0] far_limit;
    logic        pose_ok;

    item_t       pending_items[$];
    item_t       current_item;
    logic [15:0] expected_depths[$];
    int          failures;
    int          idle_cycles;
    int          send_wait;
    int          stall_wait;
    bit          draining;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_div_q14(longint v);
        longint q;
        q = v / 16384;
        if (v < 0 && q * 16384 != v)
            q = q - 1;
        return q;
    endfunction

    function automatic longint cam_coord(int k, longint d0, longint d1, longint d2);
        longint acc;
        acc = longint'($signed(rot[k][15:0])) * d0 + longint'($signed(rot[k][31:16])) * d1
            + longint'($signed(rot[k][47:32])) * d2;
        return floor_div_q14(acc);
    endfunction

    task automatic project_point(item_t it);
        longint d0, d1, d2, c0, c1, c2, u, v, r, x, y;
        d0 = longint'($signed(it.px)) - longint'($signed(cam_pos[19:0]));
        d1 = longint'($signed(it.py)) - longint'($signed(cam_pos[39:20]));
        d2 = longint'($signed(it.pz)) - longint'($signed(cam_pos[59:40]));
        c0 = cam_coord(0, d0, d1, d2);
        c1 = cam_coord(1, d0, d1, d2);
        c2 = cam_coord(2, d0, d1, d2);
        if (c0 <= MIN_DEPTH_Q10 || c0 > longint'(far_limit))
            return;
        u = (longint'(focal[15:0]) * c1 + longint'(center[15:0]) * c0) / (16 * c0);
        v = (longint'(focal[31:16]) * (-c2) + longint'(center[31:16]) * c0) / (16 * c0);
        if (u < 0 || u >= FRAME_WIDTH || v < 0 || v >= FRAME_HEIGHT)
            return;
        r = RADIUS_NUMERATOR / c0;
        if (r < 1)
            r = 1;
        if (r > MAX_SPLAT_RADIUS)
            r = MAX_SPLAT_RADIUS;
        for (y = v - r; y <= v + r; y++)
            for (x = u - r; x <= u + r; x++)
                if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT)
                    if (depth_image[y * FRAME_WIDTH + x] == 0
                        || c0[15:0] < depth_image[y * FRAME_WIDTH + x])
                        depth_image[y * FRAME_WIDTH + x] = c0[15:0];
    endtask

    task automatic predict_item(item_t it);
        int idx;
        if (it.op == OP_SPLAT)
        begin
            if (pose_ok)
                project_point(it);
        end
        else if (it.col < FRAME_WIDTH && it.row < FRAME_HEIGHT)
        begin
            idx = it.row * FRAME_WIDTH + it.col;
            expected_depths.push_back(depth_image[idx]);
            depth_image[idx] = '0;
        end
        else
            expected_depths.push_back('0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid     <= 1'b0;
            s_tdata      <= '0;
            s_tuser      <= 1'b0;
            current_item <= '0;
            send_wait    <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
        end
        else
        begin
            if (s_tvalid)
                predict_item(current_item);
            if (send_wait > 0)
            begin
                s_tvalid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_items.size() > 0)
            begin
                s_tvalid     <= 1'b1;
                s_tuser      <= pending_items[0].op;
                s_tdata      <= {1'b0, pending_items[0].row, pending_items[0].col,
                                 pending_items[0].pz, pending_items[0].py,
                                 pending_items[0].px};
                current_item <= pending_items[0];
                send_wait    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                void'(pending_items.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_depths.size() == 0)
                begin
                    $error("pixel_depth: expected none, actual %0d", m_tdata);
                    failures++;
                end
                else
                begin
                    if (m_tdata !== expected_depths[0])
                    begin
                        $error("pixel_depth: expected %0d, actual %0d",
                               expected_depths[0], m_tdata);
                        failures++;
                    end
                    void'(expected_depths.pop_front());
                end
            end
            if (stall_wait > 0)
            begin
                m_tready   <= 1'b0;
                stall_wait <= stall_wait - 1;
            end
            else
            begin
                m_tready   <= 1'b1;
                if (m_tvalid && m_tready)
                    stall_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // The watchdog allows for the store clearing pass after reset.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 1200000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [59:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            REG_ROT_ROW0:    rot[0]    = value[47:0];
            REG_ROT_ROW1:    rot[1]    = value[47:0];
            REG_ROT_ROW2:    rot[2]    = value[47:0];
            REG_TRANSLATION: cam_pos   = value;
            REG_FOCAL:       focal     = value[31:0];
            REG_PRINCIPAL:   center    = value[31:0];
            REG_MAX_DEPTH:   far_limit = value[15:0];
            REG_POSE_VALID:  pose_ok   = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_depths.size() > 0)
            @(posedge clk);
        repeat (900) @(posedge clk);
    endtask

    function automatic logic [19:0] near_coord();
        return 20'($signed(int'($urandom_range(0, 8000)) - 4000));
    endfunction

    function automatic item_t make_splat(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        item_t it;
        it = '0;
        it.op = OP_SPLAT;
        it.px = x;
        it.py = y;
        it.pz = z;
        it.col = 10'($urandom());
        it.row = 9'($urandom());
        return it;
    endfunction

    function automatic item_t make_read(logic [9:0] c, logic [8:0] r);
        item_t it;
        it = '0;
        it.op = OP_READ;
        it.px = 20'($urandom());
        it.py = 20'($urandom());
        it.pz = 20'($urandom());
        it.col = c;
        it.row = r;
        return it;
    endfunction

    // Splats land in a small window so that reads find written pixels.
    task automatic random_phase(int count);
        item_t it;
        int n;
        for (n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0: it = make_splat(20'($urandom()), 20'($urandom()), 20'($urandom()));
                1, 2, 3: it = make_read(10'($urandom()), 9'($urandom()));
                4, 5, 6: it = make_read(10'($urandom_range(280, 360)),
                                        9'($urandom_range(200, 280)));
                default: it = make_splat(20'($urandom_range(300, 6000)), near_coord(),
                                         near_coord());
            endcase
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failures  = 0;
        rot[0] = 48'd16384;
        rot[1] = 48'd1073741824;
        rot[2] = 48'd70368744177664;
        cam_pos = '0;
        focal = 32'd406067252;
        center = 32'd255267857;
        far_limit = 16'd10240;
        pose_ok = 1'b0;
        foreach (depth_image[i])
            depth_image[i] = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // No pose yet: splats are ignored.
        pending_items.push_back(make_splat(20'd1024, 20'd0, 20'd0));
        pending_items.push_back(make_read(10'd320, 9'd240));
        wait_idle();

        write_reg(REG_POSE_VALID, 60'd1);
        pending_items.push_back(make_splat(20'd1024, 20'd0, 20'd0));
        pending_items.push_back(make_splat(20'd103, 20'd0, 20'd0));
        pending_items.push_back(make_splat(20'd102, 20'd0, 20'd0));
        pending_items.push_back(make_splat(20'd10240, 20'd0, 20'd0));
        pending_items.push_back(make_splat(20'd10241, 20'd0, 20'd0));
        pending_items.push_back(make_splat(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
        pending_items.push_back(make_splat(20'h80000, 20'h80000, 20'h80000));
        pending_items.push_back(make_splat(20'd2048, 20'h80000, 20'd0));
        pending_items.push_back(make_splat(20'd512, 20'd0, 20'd0));
        pending_items.push_back(make_splat(20'd200, 20'd0, 20'd0));
        pending_items.push_back(make_read(10'd320, 9'd240));
        pending_items.push_back(make_read(10'd320, 9'd240));
        pending_items.push_back(make_read(10'd321, 9'd241));
        pending_items.push_back(make_read(10'd0, 9'd0));
        pending_items.push_back(make_read(10'd639, 9'd479));
        pending_items.push_back(make_read(10'd640, 9'd0));
        pending_items.push_back(make_read(10'd1023, 9'd511));
        pending_items.push_back(make_read(10'd0, 9'd480));
        wait_idle();
        random_phase(150);
        wait_idle();

        write_reg(REG_ROT_ROW0, {16'd0, 16'hE000, 16'd8192});
        write_reg(REG_ROT_ROW1, {16'd0, 16'd8192, 16'd8192});
        write_reg(REG_ROT_ROW2, 60'hFFFF_FFFF_FFFF);
        write_reg(REG_TRANSLATION, {20'hFFC00, 20'd512, 20'h80000});
        write_reg(REG_FOCAL, 60'hFFFF_FFFF);
        write_reg(REG_PRINCIPAL, 60'hFFFF_FFFF);
        write_reg(REG_MAX_DEPTH, 60'hFFFF);
        random_phase(100);
        wait_idle();

        write_reg(REG_ROT_ROW0, {16'h0000, 16'h0000, 16'h4000});
        write_reg(REG_ROT_ROW1, {16'h0000, 16'h4000, 16'h0000});
        write_reg(REG_ROT_ROW2, {16'h4000, 16'h0000, 16'h0000});
        write_reg(REG_TRANSLATION, 60'd0);
        write_reg(REG_FOCAL, {16'd4000, 16'd6000});
        write_reg(REG_PRINCIPAL, 60'd0);
        write_reg(REG_MAX_DEPTH, 60'd0);
        random_phase(60);
        wait_idle();

        write_reg(REG_FOCAL, 60'd406067252);
        write_reg(REG_PRINCIPAL, 60'd255267857);
        write_reg(REG_MAX_DEPTH, 60'd4000);
        random_phase(150);
        wait_idle();

        write_reg(REG_POSE_VALID, 60'd0);
        random_phase(40);
        wait_idle();
        write_reg(REG_POSE_VALID, 60'hFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MAX_DEPTH, 60'd10240);
        random_phase(50);
        wait_idle();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
